/* src/wahc_pkg.sv */
// ----------------------------------------------------------------------------
// wahc_pkg
// Shared types and constants of the word-aligned hybrid bitmap compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package wahc_pkg;

    localparam int WORD_BITS  = 32;
    localparam int LIT_BITS   = WORD_BITS - 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [LIT_BITS-1:0]  lit_t;

    localparam word_t TOP_BIT       = word_t'(1) << (WORD_BITS - 1);
    localparam word_t VAL_BIT       = word_t'(1) << (WORD_BITS - 2);
    localparam word_t LIT_MASK      = {1'b0, {LIT_BITS{1'b1}}};
    localparam word_t ZERO_FILL_MIN = TOP_BIT | word_t'(2);
    localparam word_t ONE_FILL_MIN  = TOP_BIT | VAL_BIT | word_t'(2);
    localparam word_t ZERO_FILL_MAX = TOP_BIT | (VAL_BIT - word_t'(1));
    localparam word_t ONE_FILL_MAX  = {WORD_BITS{1'b1}};
    localparam word_t HEADER_WORD   = word_t'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        K_ZLIT,
        K_OLIT,
        K_ZRUN,
        K_ORUN,
        K_LIT
    } kind_t;

    typedef struct packed {
        word_t code;
        logic  column_end;
    } result_t;

    // Up to two results produced by one input word, packed from res0.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic kind_t classify(input word_t w);
        kind_t k;
        if (w == '0)
            k = K_ZLIT;
        else if (w == LIT_MASK)
            k = K_OLIT;
        else if ((w & TOP_BIT) != '0)
            k = ((w & VAL_BIT) != '0) ? K_ORUN : K_ZRUN;
        else
            k = K_LIT;
        return k;
    endfunction

endpackage

`default_nettype wire

/* src/wahc_encoder.sv */
// ----------------------------------------------------------------------------
// wahc_encoder
// Input register, pending word and the classify / merge logic of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module wahc_encoder
    import wahc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  lit_valid,
    output logic       lit_ready,
    input  wire lit_t  literal_word,
    input  wire logic  first_of_column,
    input  wire logic  last_of_column,
    input  wire logic  push_room,
    output push_t      push
);

    logic  valid_reg;
    logic  valid_next;
    lit_t  lit_reg;
    logic  first_reg;
    logic  last_reg;
    word_t pending_reg;
    word_t pending_next;

    logic    fire;
    logic    take;
    word_t   lit_w;
    kind_t   pt;
    kind_t   nt;
    logic    emit;
    result_t lead;
    result_t flush;

    assign fire      = valid_reg && push_room;
    assign lit_ready = !valid_reg || fire;
    assign take      = lit_valid && lit_ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
                pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lit_reg   <= literal_word;
            first_reg <= first_of_column;
            last_reg  <= last_of_column;
        end
    end

    assign lit_w = {1'b0, lit_reg};
    assign pt    = classify(pending_reg);
    assign nt    = classify(lit_w);

    always_comb
    begin
        emit         = 1'b0;
        pending_next = lit_w;
        if (first_reg)
        begin
            pending_next = lit_w;
        end
        else if (nt == K_ZLIT && pt == K_ZLIT)
        begin
            pending_next = ZERO_FILL_MIN;
        end
        else if (nt == K_ZLIT && pt == K_ZRUN && pending_reg != ZERO_FILL_MAX)
        begin
            pending_next = pending_reg + word_t'(1);
        end
        else if (nt == K_OLIT && pt == K_OLIT)
        begin
            pending_next = ONE_FILL_MIN;
        end
        else if (nt == K_OLIT && pt == K_ORUN && pending_reg != ONE_FILL_MAX)
        begin
            pending_next = pending_reg + word_t'(1);
        end
        else
        begin
            emit         = 1'b1;
            pending_next = lit_w;
        end
    end

    always_comb
    begin
        lead.code        = first_reg ? HEADER_WORD : pending_reg;
        lead.column_end  = 1'b0;
        flush.code       = pending_next;
        flush.column_end = 1'b1;

        push.count = 2'd0;
        push.res0  = lead;
        push.res1  = flush;
        if (fire)
        begin
            if (first_reg || emit)
            begin
                push.count = last_reg ? 2'd2 : 2'd1;
            end
            else if (last_reg)
            begin
                push.count = 2'd1;
                push.res0  = flush;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A fill held as pending always carries a run of at least two words.
    a_fill_min: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg[WORD_BITS-1] |-> (pending_reg[WORD_BITS-3:0] >= 2)))
        else $error("pending fill count below two");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && first_reg) |->
            (push.res0.code == HEADER_WORD && !push.res0.column_end))
        else $error("column start without header word");

    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_reg) |-> (push.count != 2'd0))
        else $error("column end produced no flush word");
`endif

endmodule

`default_nettype wire

/* src/wahc_out_queue.sv */
// ----------------------------------------------------------------------------
// wahc_out_queue
// Small result queue that takes up to two code words a cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module wahc_out_queue
    import wahc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       push_room,
    output logic       code_valid,
    input  wire logic  code_ready,
    output word_t      code_word,
    output logic       column_end
);

    result_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;
    logic [QPTR_BITS-1:0]   wr_ptr_plus1;
    logic                   pop;

    assign code_valid   = (count_reg != '0);
    assign pop          = code_valid && code_ready;
    // Room is judged on the registered count; a pop in the same cycle only adds space.
    assign push_room    = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_BITS'(1);

    assign wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push.count);
    assign rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
    assign count_next  = count_reg + QCNT_BITS'(push.count) - QCNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (push.count != 2'd0 && wr_ptr_reg == QPTR_BITS'(i))
                slot_reg[i] <= push.res0;
            else if (push.count == 2'd2 && wr_ptr_plus1 == QPTR_BITS'(i))
                slot_reg[i] <= push.res1;
        end
    end

    assign code_word  = slot_reg[rd_ptr_reg].code;
    assign column_end = slot_reg[rd_ptr_reg].column_end;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> push_room)
        else $error("push into queue without room");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not follow a pop");
`endif

endmodule

`default_nettype wire

/* src/wah_bitmap_compressor.sv */
// ----------------------------------------------------------------------------
// wah_bitmap_compressor
// WAH compressor of 31-bit bitmap literals into 32-bit code words.
// ----------------------------------------------------------------------------
// An input word is taken every cycle while the result queue has room for two
// code words; it is classified in the cycle after it is taken, merged with the
// pending word once the queue has room, and its code words are queued. A word
// that ends a column and also starts one or emits a word yields two code words;
// the single output port hands out one per cycle while code_ready is high.
`default_nettype none

module wah_bitmap_compressor
    import wahc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  lit_valid,
    output logic       lit_ready,
    input  wire lit_t  literal_word,
    input  wire logic  first_of_column,
    input  wire logic  last_of_column,
    output logic       code_valid,
    input  wire logic  code_ready,
    output word_t      code_word,
    output logic       column_end
);

    push_t push;
    logic  push_room;

    wahc_encoder u_encoder (
        .clk             (clk),
        .rst_n           (rst_n),
        .lit_valid       (lit_valid),
        .lit_ready       (lit_ready),
        .literal_word    (literal_word),
        .first_of_column (first_of_column),
        .last_of_column  (last_of_column),
        .push_room       (push_room),
        .push            (push)
    );

    wahc_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_room  (push_room),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_word  (code_word),
        .column_end (column_end)
    );

endmodule

`default_nettype wire
